[hw/rtl/fcr_pkg.sv]
// Shared types and constants for the filled circle rasterizer.
package fcr_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 10;
    localparam int RADIUS_W = 8;
    localparam int DIM_W    = 9;
    localparam int CFG_IDX_W = 4;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_FILL  = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PIX,
        S_SETUP,
        S_FILL,
        S_FLUSH,
        S_DONE
    } state_t;

endpackage

[hw/rtl/fcr_if.sv]
// Channel interfaces: command, response and configuration write.
interface fcr_cmd_if
    import fcr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic [RADIUS_W-1:0]        radius;
    logic                       pixel_value;

    modport source (output valid, opcode, pos_x, pos_y, radius, pixel_value, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, radius, pixel_value, output ready);
endinterface

interface fcr_rsp_if;
    logic valid;
    logic ready;
    logic read_value;
    logic status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

interface fcr_cfg_if
    import fcr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [DIM_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/filled_circle_rasterizer_core.sv]
// Pixel write/read (or fill with an empty box): after S_PIX (or S_SETUP), the response is loaded in S_DONE.
// Fill circle: setup, one bounding-box pixel per cycle (single frame store
// write port), a drain step (S_FLUSH), then the response is loaded in S_DONE.
// One command in flight; the next is taken once the response is loaded.
// Reset: a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries (65536 by default) zeroes the
// frame store with cmd.ready low; configuration writes are taken throughout.
module filled_circle_rasterizer_core
    import fcr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
    input  logic    clk,
    input  logic    rst_n,
    fcr_cmd_if.sink cmd,
    fcr_rsp_if.source rsp,
    fcr_cfg_if.sink cfg
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CW    = (XW > YW) ? XW : YW;
    localparam int SW    = (CW + 2 > 12) ? CW + 2 : 12;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] STRIDE     = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] CLEAR_LAST = AW'(DEPTH - 1);
    localparam int SQ_W  = 2 * RADIUS_W;

    function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return AW'(AW'(y) * STRIDE + AW'(x));
    endfunction

    state_t state_reg, state_next;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [XW-1:0]    w_last;
    logic [YW-1:0]    h_last;
    logic signed [SW-1:0] w_lim_s, h_lim_s;

    logic [AW-1:0] clr_reg;

    // Command word
    logic [OPCODE_W-1:0]     cmd_op_reg;
    logic signed [POS_W-1:0] cmd_x_reg, cmd_y_reg;
    logic [RADIUS_W-1:0]     cmd_r_reg;
    logic                    cmd_val_reg;
    logic                    cmd_inside_reg;

    logic signed [SW-1:0] in_x_s, in_y_s;
    logic                 in_inside;

    // Bounding box and scan
    logic signed [SW-1:0] cx_s, cy_s, r_s;
    logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y;
    logic                 box_empty;
    logic [XW-1:0]        bx0, bx1;
    logic [YW-1:0]        by0, by1;
    logic [XW-1:0]        x0_reg, x1_reg, sx_reg;
    logic [YW-1:0]        y1_reg, sy_reg;
    logic [SQ_W-1:0]      rr_reg;
    logic                 scan_last;

    // Distance pipeline
    logic signed [SW-1:0] sx_s, sy_s, dx_s, dy_s, dx_m, dy_m;
    logic [RADIUS_W-1:0]  dx_abs, dy_abs;
    logic                 p1_valid_reg;
    logic [SQ_W-1:0]      p1_dx2_reg, p1_dy2_reg;
    logic [AW-1:0]        p1_addr_reg;
    logic [SQ_W:0]        dist2;
    logic                 hit;

    // Frame store
    logic          frame_mem [DEPTH];
    logic          mem_we, mem_wdata, mem_re;
    logic [AW-1:0] mem_waddr, cmd_addr;
    logic          rd_data_reg;

    logic rsp_valid_reg, rsp_read_reg, rsp_status_reg;
    logic load_rsp, cmd_take, fill_issue;

    // Effective image limits: 0 acts as 1, above the maximum acts as the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_last = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            w_last = XW'(MAX_WIDTH - 1);
        else
            w_last = XW'(width_reg - DIM_W'(1));
        if (height_reg == '0)
            h_last = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            h_last = YW'(MAX_HEIGHT - 1);
        else
            h_last = YW'(height_reg - DIM_W'(1));
    end

    assign w_lim_s = SW'({1'b0, w_last});
    assign h_lim_s = SW'({1'b0, h_last});

    assign in_x_s    = SW'(cmd.pos_x);
    assign in_y_s    = SW'(cmd.pos_y);
    assign in_inside = (in_x_s >= 0) && (in_x_s <= w_lim_s)
                    && (in_y_s >= 0) && (in_y_s <= h_lim_s);

    assign cx_s = SW'(cmd_x_reg);
    assign cy_s = SW'(cmd_y_reg);
    assign r_s  = SW'({1'b0, cmd_r_reg});
    assign lo_x = cx_s - r_s;
    assign hi_x = cx_s + r_s;
    assign lo_y = cy_s - r_s;
    assign hi_y = cy_s + r_s;
    assign box_empty = (hi_x < 0) || (lo_x > w_lim_s) || (hi_y < 0) || (lo_y > h_lim_s);
    assign bx0 = (lo_x < 0) ? '0 : lo_x[XW-1:0];
    assign bx1 = (hi_x > w_lim_s) ? w_last : hi_x[XW-1:0];
    assign by0 = (lo_y < 0) ? '0 : lo_y[YW-1:0];
    assign by1 = (hi_y > h_lim_s) ? h_last : hi_y[YW-1:0];

    assign scan_last = (sx_reg == x1_reg) && (sy_reg == y1_reg);

    assign sx_s   = SW'({1'b0, sx_reg});
    assign sy_s   = SW'({1'b0, sy_reg});
    assign dx_s   = sx_s - cx_s;
    assign dy_s   = sy_s - cy_s;
    assign dx_m   = dx_s[SW-1] ? -dx_s : dx_s;
    assign dy_m   = dy_s[SW-1] ? -dy_s : dy_s;
    assign dx_abs = dx_m[RADIUS_W-1:0];
    assign dy_abs = dy_m[RADIUS_W-1:0];

    assign dist2 = (SQ_W + 1)'(p1_dx2_reg) + (SQ_W + 1)'(p1_dy2_reg);
    assign hit   = dist2 <= (SQ_W + 1)'(rr_reg);

    assign cmd_addr = pix_addr(cx_s[XW-1:0], cy_s[YW-1:0]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == CLEAR_LAST) state_next = S_IDLE;
            S_IDLE:
            begin
                if (cmd.valid)
                    state_next = (cmd.opcode == OP_FILL) ? S_SETUP : S_PIX;
            end
            S_PIX:   state_next = S_DONE;
            S_SETUP: state_next = box_empty ? S_DONE : S_FILL;
            S_FILL:  if (scan_last) state_next = S_FLUSH;
            S_FLUSH: state_next = S_DONE;
            S_DONE:  if (load_rsp) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        cmd_take   = 1'b0;
        fill_issue = 1'b0;
        load_rsp   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = p1_addr_reg;
        mem_wdata  = cmd_val_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
            end
            S_IDLE:  cmd_take = cmd.valid;
            S_PIX:
            begin
                mem_we    = (cmd_op_reg == OP_WRITE) && cmd_inside_reg;
                mem_re    = (cmd_op_reg == OP_READ) && cmd_inside_reg;
                mem_waddr = cmd_addr;
            end
            S_FILL:
            begin
                fill_issue = 1'b1;
                mem_we     = p1_valid_reg && hit;
            end
            S_FLUSH: mem_we = p1_valid_reg && hit;
            S_DONE:  load_rsp = !rsp_valid_reg || rsp.ready;
            default: ;
        endcase
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
            p1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg.data;
                    default: ;
                endcase
            end
            p1_valid_reg <= fill_issue;
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_op_reg     <= cmd.opcode;
            cmd_x_reg      <= cmd.pos_x;
            cmd_y_reg      <= cmd.pos_y;
            cmd_r_reg      <= cmd.radius;
            cmd_val_reg    <= cmd.pixel_value;
            cmd_inside_reg <= in_inside;
        end
        if (state_reg == S_SETUP)
        begin
            x0_reg <= bx0;
            x1_reg <= bx1;
            y1_reg <= by1;
            sx_reg <= bx0;
            sy_reg <= by0;
            rr_reg <= SQ_W'(cmd_r_reg) * SQ_W'(cmd_r_reg);
        end
        else if (fill_issue)
        begin
            if (sx_reg == x1_reg)
            begin
                sx_reg <= x0_reg;
                sy_reg <= sy_reg + YW'(1);
            end
            else
                sx_reg <= sx_reg + XW'(1);
        end
        p1_dx2_reg  <= SQ_W'(dx_abs) * SQ_W'(dx_abs);
        p1_dy2_reg  <= SQ_W'(dy_abs) * SQ_W'(dy_abs);
        p1_addr_reg <= pix_addr(sx_reg, sy_reg);
        if (load_rsp)
        begin
            rsp_read_reg   <= (cmd_op_reg == OP_READ) && cmd_inside_reg && rd_data_reg;
            rsp_status_reg <= ((cmd_op_reg == OP_WRITE) || (cmd_op_reg == OP_READ))
                              && !cmd_inside_reg;
        end
    end

    // Frame store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= frame_mem[cmd_addr];
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_read_reg;
    assign rsp.status     = rsp_status_reg;

endmodule

[hw/rtl/fcr_checker.sv]
// Port-level checks for the rasterizer core, bound into the core module.
module fcr_checker (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic read_value,
    input logic status
);

    // One command at a time: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command taken while previous one in progress");

    // A fresh response is loaded on the way back to idle
    a_rsp_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> cmd_ready)
        else $error("response raised while block busy");

    // A read result and an out-of-image flag never come together
    a_read_vs_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(read_value && status))
        else $error("read value set on an ignored access");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(read_value) && $stable(status)))
        else $error("response word changed while stalled");

endmodule

bind filled_circle_rasterizer_core fcr_checker u_fcr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .read_value (rsp.read_value),
    .status     (rsp.status)
);
